// ===== rtl/l1ns_pkg.sv =====
// Package for the L1-norm insertion sort core: field widths, config register
// codes, payload structs and the magnitude helper. No dependencies.
`default_nettype none

package l1ns_pkg;

  // Fixed field widths
  localparam int ELEM_W     = 32;
  localparam int NORM_W     = 38;
  localparam int DIM_W      = 7;
  localparam int BASE_W     = 8;
  localparam int OIDX_W     = 9;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // Defaults for the top-level parameters
  localparam int MAX_VECTORS_DEF = 64;
  localparam int MAX_DIM_DEF     = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VECTOR_DIM = 1'b0,
    REG_INDEX_BASE = 1'b1
  } cfg_reg_e;

  // One input transaction
  typedef struct packed {
    logic signed [ELEM_W-1:0] element_value;
    logic                     last_of_set;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [OIDX_W-1:0] original_index;
    logic [NORM_W-1:0] norm;
    logic              last;
  } result_t;

  // Absolute value of a signed element, one bit wider so -2^31 fits
  function automatic logic [ELEM_W:0] abs_mag(input logic signed [ELEM_W-1:0] v);
    logic [ELEM_W:0] ext;
    ext = {v[ELEM_W-1], v};
    return v[ELEM_W-1] ? (~ext + 1'b1) : ext;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/l1ns_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module l1ns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/l1ns_loader.sv =====
// Load path: per-element magnitude accumulation, element and vector counting,
// and record writes {norm, load index} into the sort RAM. Uses l1ns_pkg.
`default_nettype none

module l1ns_loader #(
  parameter int MAX_VECTORS = l1ns_pkg::MAX_VECTORS_DEF,
  parameter int MAX_DIM     = l1ns_pkg::MAX_DIM_DEF,
  localparam int IDX_W = $clog2(MAX_VECTORS),
  localparam int CNT_W = $clog2(MAX_VECTORS + 1),
  localparam int REC_W = l1ns_pkg::NORM_W + IDX_W
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire l1ns_pkg::item_t            item_i,
  input  wire logic [l1ns_pkg::DIM_W-1:0] vdim_i,
  output logic                            we_o,
  output logic      [IDX_W-1:0]           waddr_o,
  output logic      [REC_W-1:0]           wdata_o,
  output logic                            go_o,
  output logic      [CNT_W-1:0]           count_o
);

  import l1ns_pkg::*;

  localparam int ECNT_W = $clog2(MAX_DIM + 1);

  logic [NORM_W-1:0] acc_q, acc_d, acc_sum;
  logic [ECNT_W-1:0] ecnt_q, ecnt_d, ecnt_inc;
  logic [CNT_W-1:0]  vcnt_q, vcnt_d, vcnt_after;
  logic [DIM_W-1:0]  eff_dim;
  logic [ELEM_W:0]   mag;
  logic              close, keep;

  // Effective dimension: zero acts as one, clamp to MAX_DIM
  always_comb begin
    if (vdim_i == '0) begin
      eff_dim = DIM_W'(1);
    end else if (vdim_i > DIM_W'(MAX_DIM)) begin
      eff_dim = DIM_W'(MAX_DIM);
    end else begin
      eff_dim = vdim_i;
    end
  end

  // Accumulate and decide whether this element closes a vector
  always_comb begin
    mag        = abs_mag(item_i.element_value);
    acc_sum    = acc_q + NORM_W'(mag);
    ecnt_inc   = ecnt_q + ECNT_W'(1);
    close      = accept_i && ((DIM_W'(ecnt_inc) >= eff_dim) || item_i.last_of_set);
    keep       = vcnt_q < CNT_W'(MAX_VECTORS);
    we_o       = close && keep;
    waddr_o    = vcnt_q[IDX_W-1:0];
    wdata_o    = {acc_sum, vcnt_q[IDX_W-1:0]};
    vcnt_after = we_o ? (vcnt_q + CNT_W'(1)) : vcnt_q;
    go_o       = accept_i && item_i.last_of_set;
    count_o    = vcnt_after;

    acc_d  = acc_q;
    ecnt_d = ecnt_q;
    vcnt_d = vcnt_q;
    if (accept_i) begin
      if (item_i.last_of_set) begin
        acc_d  = '0;
        ecnt_d = '0;
        vcnt_d = '0;
      end else if (close) begin
        acc_d  = '0;
        ecnt_d = '0;
        vcnt_d = vcnt_after;
      end else begin
        acc_d  = acc_sum;
        ecnt_d = ecnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      ecnt_q <= '0;
      vcnt_q <= '0;
    end else begin
      acc_q  <= acc_d;
      ecnt_q <= ecnt_d;
      vcnt_q <= vcnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/l1ns_sorter.sv =====
// Sort and emit sequencer: stable in-place insertion sort over the records in
// the sort RAM, then reads them out in order as results. Uses l1ns_pkg.
`default_nettype none

module l1ns_sorter #(
  parameter int MAX_VECTORS = l1ns_pkg::MAX_VECTORS_DEF,
  localparam int IDX_W = $clog2(MAX_VECTORS),
  localparam int CNT_W = $clog2(MAX_VECTORS + 1),
  localparam int REC_W = l1ns_pkg::NORM_W + IDX_W
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        go_i,
  input  wire logic [CNT_W-1:0]            count_i,
  input  wire logic [l1ns_pkg::BASE_W-1:0] base_i,
  input  wire logic [REC_W-1:0]            rdata_i,
  output logic                             re_o,
  output logic      [IDX_W-1:0]            raddr_o,
  output logic                             we_o,
  output logic      [IDX_W-1:0]            waddr_o,
  output logic      [REC_W-1:0]            wdata_o,
  output logic                             busy_o,
  output logic                             valid_o,
  output l1ns_pkg::result_t                result_o
);

  import l1ns_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_RD,
    ST_KEY_CAP,
    ST_SHIFT,
    ST_PLACE,
    ST_EMIT,
    ST_DRAIN
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   j_q, j_d, pos_q, pos_d, k_q, k_d;
  logic [REC_W-1:0]   key_q, key_d;
  logic               valid_q, valid_d, last_q, last_d;
  logic [NORM_W-1:0]  rd_norm, key_norm;
  logic [IDX_W-1:0]   rd_idx;
  logic               j_done;

  assign rd_norm  = rdata_i[REC_W-1:IDX_W];
  assign rd_idx   = rdata_i[IDX_W-1:0];
  assign key_norm = key_q[REC_W-1:IDX_W];
  assign j_done   = (CNT_W'(j_q) + CNT_W'(1)) == cnt_q;

  // Sequencer. Writes always go to the slot above the pending read, so the
  // read and write ports never touch the same entry in one cycle.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    j_d     = j_q;
    pos_d   = pos_q;
    k_d     = k_q;
    key_d   = key_q;
    valid_d = 1'b0;
    last_d  = 1'b0;
    re_o    = 1'b0;
    raddr_o = '0;
    we_o    = 1'b0;
    waddr_o = '0;
    wdata_o = key_q;

    case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          cnt_d = count_i;
          j_d   = IDX_W'(1);
          k_d   = '0;
          state_d = (count_i == CNT_W'(1)) ? ST_EMIT : ST_KEY_RD;
        end
      end
      // Fetch record j
      ST_KEY_RD: begin
        re_o    = 1'b1;
        raddr_o = j_q;
        state_d = ST_KEY_CAP;
      end
      // Latch the key, fetch its left neighbor
      ST_KEY_CAP: begin
        key_d   = rdata_i;
        pos_d   = j_q;
        re_o    = 1'b1;
        raddr_o = j_q - IDX_W'(1);
        state_d = ST_SHIFT;
      end
      // Strictly greater neighbor moves right; equal norms stay put
      ST_SHIFT: begin
        we_o    = 1'b1;
        waddr_o = pos_q;
        if (rd_norm > key_norm) begin
          wdata_o = rdata_i;
          pos_d   = pos_q - IDX_W'(1);
          if (pos_q == IDX_W'(1)) begin
            state_d = ST_PLACE;
          end else begin
            re_o    = 1'b1;
            raddr_o = pos_q - IDX_W'(1) - IDX_W'(1);
          end
        end else begin
          wdata_o = key_q;
          if (j_done) begin
            k_d     = '0;
            state_d = ST_EMIT;
          end else begin
            j_d     = j_q + IDX_W'(1);
            state_d = ST_KEY_RD;
          end
        end
      end
      // Key goes to the front
      ST_PLACE: begin
        we_o    = 1'b1;
        waddr_o = '0;
        wdata_o = key_q;
        if (j_done) begin
          k_d     = '0;
          state_d = ST_EMIT;
        end else begin
          j_d     = j_q + IDX_W'(1);
          state_d = ST_KEY_RD;
        end
      end
      // Read out in sorted order; data and valid show in the next cycle
      ST_EMIT: begin
        re_o    = 1'b1;
        raddr_o = k_q;
        valid_d = 1'b1;
        last_d  = (CNT_W'(k_q) + CNT_W'(1)) == cnt_q;
        k_d     = k_q + IDX_W'(1);
        if (last_d) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      j_q     <= '0;
      pos_q   <= '0;
      k_q     <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      j_q     <= j_d;
      pos_q   <= pos_d;
      k_q     <= k_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  // Key register carries payload only
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // Result fields come straight from the registered RAM read
  assign busy_o                  = (state_q != ST_IDLE);
  assign valid_o                 = valid_q;
  assign result_o.original_index = OIDX_W'(base_i) + OIDX_W'(rd_idx);
  assign result_o.norm           = rd_norm;
  assign result_o.last           = last_q;

endmodule

`default_nettype wire

// ===== rtl/l1_norm_insertion_sort_core.sv =====
// Top level of the L1-norm insertion sort core: config registers, loader,
// sort/emit sequencer and the record RAM. Uses l1ns_pkg, l1ns_ram,
// l1ns_loader and l1ns_sorter.
//
//   channel   | ports                                 | handshake
//   ----------+---------------------------------------+------------------------------
//   input     | start_i, busy_o, item_i               | taken when start_i && !busy_o
//   result    | valid_o, result_o                     | one-cycle strobe, no back-pressure
//   config    | cfg_we_i, cfg_idx_i, cfg_data_i       | written when cfg_we_i is high
//
// Loading takes one element per cycle with busy_o low. The element with
// last_of_set raises busy_o for the sort and read-out of the n stored vectors.
// The sort runs on the single read port of the record RAM, one compare per cycle
// while a key shifts. Reset clears control only; the RAM needs no clearing since
// every entry read was written during the current set. Results cannot be stalled.
`default_nettype none

module l1_norm_insertion_sort_core #(
  parameter int MAX_VECTORS = l1ns_pkg::MAX_VECTORS_DEF,
  parameter int MAX_DIM     = l1ns_pkg::MAX_DIM_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire l1ns_pkg::item_t                 item_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [l1ns_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [l1ns_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                 valid_o,
  output l1ns_pkg::result_t                    result_o
);

  import l1ns_pkg::*;

  localparam int IDX_W = $clog2(MAX_VECTORS);
  localparam int CNT_W = $clog2(MAX_VECTORS + 1);
  localparam int REC_W = NORM_W + IDX_W;

  logic [DIM_W-1:0]  vdim_q;
  logic [BASE_W-1:0] base_q;
  logic              accept;
  logic              ld_we, so_we, so_re, go;
  logic [IDX_W-1:0]  ld_waddr, so_waddr, so_raddr, ram_waddr;
  logic [REC_W-1:0]  ld_wdata, so_wdata, ram_wdata, ram_rdata;
  logic [CNT_W-1:0]  count;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdim_q <= DIM_W'(1);
      base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_VECTOR_DIM: vdim_q <= cfg_data_i[DIM_W-1:0];
        REG_INDEX_BASE: base_q <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = start_i && !busy_o;

  l1ns_loader #(
    .MAX_VECTORS (MAX_VECTORS),
    .MAX_DIM     (MAX_DIM)
  ) u_loader (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .vdim_i   (vdim_q),
    .we_o     (ld_we),
    .waddr_o  (ld_waddr),
    .wdata_o  (ld_wdata),
    .go_o     (go),
    .count_o  (count)
  );

  l1ns_sorter #(
    .MAX_VECTORS (MAX_VECTORS)
  ) u_sorter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (go),
    .count_i  (count),
    .base_i   (base_q),
    .rdata_i  (ram_rdata),
    .re_o     (so_re),
    .raddr_o  (so_raddr),
    .we_o     (so_we),
    .waddr_o  (so_waddr),
    .wdata_o  (so_wdata),
    .busy_o   (busy_o),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  // Loader writes only while idle, sorter only while busy
  assign ram_waddr = ld_we ? ld_waddr : so_waddr;
  assign ram_wdata = ld_we ? ld_wdata : so_wdata;

  l1ns_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_VECTORS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we || so_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (so_re),
    .raddr_i (so_raddr),
    .rdata_o (ram_rdata)
  );

  // Results appear only during a sort run
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result strobe outside a sort run");

  // Final element of a set starts a sort run
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.last_of_set) |=> busy_o)
    else $error("set end did not start sorting");

  // A run ends only right after its final result
  a_end_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(valid_o && result_o.last))
    else $error("run ended without final result");

  // Nothing follows the final result
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.last) |=> !valid_o)
    else $error("result after final result");

endmodule

`default_nettype wire

// ===== tb/l1_norm_insertion_sort_core_tb.sv =====
// Self-checking testbench for l1_norm_insertion_sort_core: a queue-fed driver, a result
// monitor with an in-bench predictor of norms and sort order, and a watchdog.
// Depends on l1ns_pkg and the l1_norm_insertion_sort_core RTL.
`default_nettype none

module l1_norm_insertion_sort_core_tb;
  import l1ns_pkg::*;

  localparam int NVEC       = MAX_VECTORS_DEF;
  localparam int NDIM       = MAX_DIM_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYC = 8;

  // Pending input transaction; settle makes the driver wait for all results after it
  typedef struct packed {
    item_t item;
    logic  settle;
  } feed_t;

  logic    clk_i      = 1'b0;
  logic    rst_ni     = 1'b0;
  logic    start_i    = 1'b0;
  item_t   item_i     = '0;
  logic    cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = REG_VECTOR_DIM;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic    busy_o;
  logic    valid_o;
  result_t result_o;

  feed_t   feed_q[$];
  result_t sorted_q[$];
  feed_t   next_feed;
  logic    item_taken  = 1'b0;
  logic    settle_wait = 1'b0;
  int      gap_left    = 0;
  int      err_count   = 0;
  int      idle_cycles = 0;

  // Predictor state: stored norms, running vector, register copies
  logic [NORM_W-1:0] norm_mem [NVEC];
  logic [NORM_W-1:0] run_norm   = '0;
  int                run_elems  = 0;
  int                vec_count  = 0;
  logic [DIM_W-1:0]  dim_reg    = DIM_W'(1);
  logic [BASE_W-1:0] base_reg   = '0;

  l1_norm_insertion_sort_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .valid_o    (valid_o),
    .result_o   (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Store the running norm as a vector; vectors past capacity are dropped
  task automatic close_vector();
    if (vec_count < NVEC) begin
      norm_mem[vec_count] = run_norm;
      vec_count++;
    end
    run_norm  = '0;
    run_elems = 0;
  endtask

  // Accumulate one element; on the end of a set, sort stably and queue the results
  task automatic predict_l1_order(input item_t it);
    logic [ELEM_W:0] mag;
    int              dim_eff;
    int              order [NVEC];
    int              key;
    int              slot;
    result_t         r;
    if (it.element_value[ELEM_W-1])
      mag = {1'b1, {ELEM_W{1'b0}}} - {1'b0, it.element_value};
    else
      mag = {1'b0, it.element_value};
    run_norm = run_norm + NORM_W'(mag);
    run_elems++;
    dim_eff = (dim_reg == '0) ? 1 : ((int'(dim_reg) > NDIM) ? NDIM : int'(dim_reg));
    if (run_elems >= dim_eff) close_vector();
    if (it.last_of_set) begin
      // a partial final vector still counts
      if (run_elems != 0) close_vector();
      for (int j = 0; j < vec_count; j++) order[j] = j;
      for (int j = 1; j < vec_count; j++) begin
        key  = order[j];
        slot = j;
        while (slot > 0 && norm_mem[order[slot-1]] > norm_mem[key]) begin
          order[slot] = order[slot-1];
          slot--;
        end
        order[slot] = key;
      end
      for (int k = 0; k < vec_count; k++) begin
        r.original_index = OIDX_W'(base_reg) + OIDX_W'(order[k]);
        r.norm           = norm_mem[order[k]];
        r.last           = (k == vec_count - 1);
        sorted_q.push_back(r);
      end
      vec_count = 0;
      run_norm  = '0;
      run_elems = 0;
    end
  endtask

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      err_count++;
    end
  endfunction

  // Gaps between offers: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(ELEM_W-1){1'b0}}};
      1:       return {1'b0, {(ELEM_W-1){1'b1}}};
      2, 3, 4: return ELEM_W'($urandom_range(0, 8)) - ELEM_W'(4);
      default: return $urandom;
    endcase
  endfunction

  // Driver: hold an offer until taken, then gap, settle or offer the next one
  always @(negedge clk_i) begin
    if (start_i && !item_taken) begin
      // offer stays up while the core is busy
    end else if (gap_left != 0) begin
      start_i <= 1'b0;
      gap_left--;
    end else if (settle_wait && sorted_q.size() != 0) begin
      start_i <= 1'b0;
    end else if (feed_q.size() != 0) begin
      next_feed   = feed_q.pop_front();
      item_i      <= next_feed.item;
      start_i     <= 1'b1;
      settle_wait = next_feed.settle;
      gap_left    = pick_gap();
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: register writes, accepted transactions and result checks
  always @(posedge clk_i) begin
    item_taken <= start_i && !busy_o;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_VECTOR_DIM) dim_reg = cfg_data_i[DIM_W-1:0];
        else base_reg = cfg_data_i[BASE_W-1:0];
      end
      if (valid_o) begin
        if (sorted_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result_o);
          err_count++;
        end else begin
          check_field("original_index", 64'(sorted_q[0].original_index),
                      64'(result_o.original_index));
          check_field("norm", 64'(sorted_q[0].norm), 64'(result_o.norm));
          check_field("last", 64'(sorted_q[0].last), 64'(result_o.last));
          void'(sorted_q.pop_front());
        end
      end
      if (start_i && !busy_o) predict_l1_order(item_i);
    end
  end

  // Watchdog: no transaction for too long while work is outstanding
  always @(posedge clk_i) begin
    if ((feed_q.size() != 0 || start_i || sorted_q.size() != 0) &&
        !(start_i && !busy_o) && !valid_o)
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_elem(input logic signed [ELEM_W-1:0] v, input logic lst,
                           input logic settle);
    feed_t f;
    f.item.element_value = v;
    f.item.last_of_set   = lst;
    f.settle             = settle;
    feed_q.push_back(f);
  endtask

  // Wait until every queued transaction is taken and every result has arrived
  task automatic wait_drained();
    while (feed_q.size() != 0 || start_i || sorted_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic int eff_dim_of(input logic [CFG_DATA_W-1:0] data);
    int d;
    d = int'(data[DIM_W-1:0]);
    if (d == 0) return 1;
    return (d > NDIM) ? NDIM : d;
  endfunction

  initial begin
    int                    rand_items;
    int                    cur_dim;
    int                    nvec;
    int                    total;
    logic [CFG_DATA_W-1:0] dval;
    logic                  reconfig;
    rand_items = 0;
    cur_dim    = 1;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults, one-element vectors, field extremes
    push_elem(0, 1'b0, 1'b0);
    push_elem(-1, 1'b0, 1'b0);
    push_elem({1'b0, {(ELEM_W-1){1'b1}}}, 1'b0, 1'b0);
    push_elem({1'b1, {(ELEM_W-1){1'b0}}}, 1'b1, 1'b0);
    wait_drained();

    // Three-element vectors, equal norms, partial final vector, index past 255
    write_reg(REG_VECTOR_DIM, 8'd3);
    write_reg(REG_INDEX_BASE, 8'd255);
    push_elem(5, 1'b0, 1'b0);
    push_elem(-5, 1'b0, 1'b0);
    push_elem(0, 1'b0, 1'b0);
    push_elem(3, 1'b0, 1'b0);
    push_elem(3, 1'b0, 1'b0);
    push_elem(-4, 1'b0, 1'b0);
    push_elem({1'b1, {(ELEM_W-1){1'b0}}}, 1'b0, 1'b0);
    push_elem({1'b0, {(ELEM_W-1){1'b1}}}, 1'b1, 1'b1);
    wait_drained();

    // Dimension lowered while a vector is half loaded
    write_reg(REG_VECTOR_DIM, 8'd4);
    write_reg(REG_INDEX_BASE, 8'd0);
    push_elem(1, 1'b0, 1'b0);
    push_elem(2, 1'b0, 1'b0);
    push_elem(-3, 1'b0, 1'b0);
    wait_drained();
    write_reg(REG_VECTOR_DIM, 8'd2);
    push_elem(4, 1'b0, 1'b0);
    push_elem(-7, 1'b1, 1'b0);
    wait_drained();

    // Dimension zero behaves as one
    write_reg(REG_VECTOR_DIM, 8'd0);
    push_elem(9, 1'b0, 1'b0);
    push_elem(-9, 1'b0, 1'b0);
    push_elem(1, 1'b1, 1'b0);
    wait_drained();

    // Oversized dimension clamps to the maximum; full vector of most negative values
    write_reg(REG_VECTOR_DIM, 8'hFF);
    write_reg(REG_INDEX_BASE, 8'd200);
    for (int k = 0; k < NDIM + 1; k++)
      push_elem({1'b1, {(ELEM_W-1){1'b0}}}, (k == NDIM), 1'b0);
    wait_drained();

    // More vectors than fit: descending small norms with ties, extras dropped
    write_reg(REG_VECTOR_DIM, 8'd1);
    write_reg(REG_INDEX_BASE, 8'd255);
    for (int k = 0; k < NVEC + 2; k++)
      push_elem($urandom_range(0, 1) ? ELEM_W'((NVEC + 2 - k) / 3)
                                     : -ELEM_W'((NVEC + 2 - k) / 3),
                (k == NVEC + 1), 1'b0);
    wait_drained();

    // Random sets, reconfigured now and then, some mid-set
    while (rand_items < 16) begin
      reconfig = ($urandom_range(0, 9) < 4);
      if (reconfig) begin
        wait_drained();
        case ($urandom_range(0, 19))
          0:       dval = 8'd0;
          1:       dval = CFG_DATA_W'($urandom_range(65, 255));
          2:       dval = 8'd64;
          3, 4, 5: dval = CFG_DATA_W'($urandom_range(5, 8));
          default: dval = CFG_DATA_W'($urandom_range(1, 4));
        endcase
        write_reg(REG_VECTOR_DIM, dval);
        cur_dim = eff_dim_of(dval);
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 9))
            0:       dval = 8'd0;
            1:       dval = 8'd255;
            default: dval = CFG_DATA_W'($urandom);
          endcase
          write_reg(REG_INDEX_BASE, dval);
        end
      end
      if (cur_dim > 8) begin
        nvec  = 1;
        total = $urandom_range(1, 6);
      end else begin
        nvec  = $urandom_range(1, 6);
        total = nvec * cur_dim;
        if ($urandom_range(0, 3) == 0) total = total - $urandom_range(0, cur_dim - 1);
      end
      for (int e = 0; e < total; e++) begin
        if (nvec > 1 && e == total / 2 && $urandom_range(0, 9) == 0) begin
          wait_drained();
          dval = CFG_DATA_W'($urandom_range(1, 4));
          write_reg(REG_VECTOR_DIM, dval);
          cur_dim = eff_dim_of(dval);
        end
        push_elem(pick_element(), (e == total - 1),
                  (e == total - 1) && ($urandom_range(0, 9) < 3));
      end
      rand_items += total;
    end

    wait_drained();
    repeat (50) @(negedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/l1ns_pkg.sv
rtl/l1ns_ram.sv
rtl/l1ns_loader.sv
rtl/l1ns_sorter.sv
rtl/l1_norm_insertion_sort_core.sv
tb/l1_norm_insertion_sort_core_tb.sv
